// ===== rtl/core/srml_pkg.sv =====
`timescale 1ns / 1ps

package srml_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam int POS_W           = 32;

  // request codes
  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // one stored pair
  typedef struct packed {
    logic [POS_W-1:0] key;
    logic [POS_W-1:0] value;
  } entry_t;

  // one result
  typedef struct packed {
    logic [POS_W-1:0] found_position;
    logic             table_full;
  } res_t;

endpackage

// ===== rtl/core/srml_if.sv =====
`timescale 1ns / 1ps

interface srml_req_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  req_type;
  logic [srml_pkg::POS_W-1:0]  code_position;
  logic [srml_pkg::POS_W-1:0]  source_position;

  modport source (output valid, req_type, code_position, source_position, input ready);
  modport sink   (input valid, req_type, code_position, source_position, output ready);
endinterface

interface srml_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [srml_pkg::POS_W-1:0]  found_position;
  logic                        table_full;

  modport source (output valid, found_position, table_full, input ready);
  modport sink   (input valid, found_position, table_full, output ready);
endinterface

// ===== rtl/core/srml_store.sv =====
`timescale 1ns / 1ps

module srml_store #(
  parameter int TABLE_DEPTH = srml_pkg::TABLE_DEPTH_DEF
) (
  input  logic                                             clk,
  input  logic                                             we,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] waddr,
  input  srml_pkg::entry_t                                 wdata,
  input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] raddr,
  output srml_pkg::entry_t                                 rdata
);

  srml_pkg::entry_t mem [TABLE_DEPTH];
  srml_pkg::entry_t rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/srml_ctrl.sv =====
`timescale 1ns / 1ps

module srml_ctrl #(
  parameter int TABLE_DEPTH = srml_pkg::TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        req_valid,
  output logic                        req_ready,
  input  logic [1:0]                  req_type,
  input  logic [srml_pkg::POS_W-1:0]  code_position,
  input  logic [srml_pkg::POS_W-1:0]  source_position,
  output logic                        res_valid,
  input  logic                        res_take,
  output srml_pkg::res_t              res,
  output logic                        mem_we,
  output logic [IDX_W-1:0]            mem_waddr,
  output srml_pkg::entry_t            mem_wdata,
  output logic [IDX_W-1:0]            mem_raddr,
  input  srml_pkg::entry_t            mem_rdata
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_PROBE = 3'd1;
  localparam logic [2:0] ST_CMP   = 3'd2;
  localparam logic [2:0] ST_VREAD = 3'd3;
  localparam logic [2:0] ST_VWAIT = 3'd4;
  localparam logic [2:0] ST_SHIFT = 3'd5;
  localparam logic [2:0] ST_RESP  = 3'd6;

  localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);
  localparam logic [CNT_W-1:0] ONE_C   = CNT_W'(1);

  logic [2:0]                 state_r, state_nxt;
  logic [CNT_W-1:0]           count_r, count_nxt;
  logic [CNT_W-1:0]           lo_r, lo_nxt;
  logic [CNT_W-1:0]           hi_r, hi_nxt;
  logic [CNT_W-1:0]           mid_r, mid_nxt;
  logic [CNT_W-1:0]           slot_r, slot_nxt;
  logic [CNT_W-1:0]           i_r, i_nxt;
  logic [CNT_W-1:0]           wr_addr_r, wr_addr_nxt;
  logic                       pend_r, pend_nxt;
  logic                       is_ins_r, is_ins_nxt;
  logic [srml_pkg::POS_W-1:0] q_r, q_nxt;
  logic [srml_pkg::POS_W-1:0] src_r, src_nxt;
  srml_pkg::res_t             res_r, res_nxt;
  logic [CNT_W:0]             mid_sum;
  logic                       key_gt;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign key_gt  = mem_rdata.key > q_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    slot_nxt    = slot_r;
    i_nxt       = i_r;
    wr_addr_nxt = wr_addr_r;
    pend_nxt    = pend_r;
    is_ins_nxt  = is_ins_r;
    q_nxt       = q_r;
    src_nxt     = src_r;
    res_nxt     = res_r;
    mem_we      = 1'b0;
    mem_waddr   = wr_addr_r[IDX_W-1:0];
    mem_wdata   = mem_rdata;
    mem_raddr   = mid_r[IDX_W-1:0];

    unique case (state_r)
      ST_IDLE: begin
        if (req_valid) begin
          q_nxt   = code_position;
          src_nxt = source_position;
          res_nxt = '0;
          lo_nxt  = '0;
          hi_nxt  = count_r;
          unique case (req_type)
            srml_pkg::REQ_CLEAR: begin
              count_nxt = '0;
              state_nxt = ST_RESP;
            end
            srml_pkg::REQ_INSERT: begin
              is_ins_nxt = 1'b1;
              if (count_r == DEPTH_C) begin
                res_nxt.table_full = 1'b1;
                state_nxt          = ST_RESP;
              end else if (count_r == '0) begin
                slot_nxt  = '0;
                i_nxt     = '0;
                pend_nxt  = 1'b0;
                state_nxt = ST_SHIFT;
              end else begin
                state_nxt = ST_PROBE;
              end
            end
            srml_pkg::REQ_LOOKUP: begin
              is_ins_nxt = 1'b0;
              if (count_r == '0) begin
                state_nxt = ST_RESP;
              end else if (count_r == ONE_C) begin
                state_nxt = ST_VREAD;
              end else begin
                state_nxt = ST_PROBE;
              end
            end
            default: begin
              state_nxt = ST_RESP;
            end
          endcase
        end
      end
      ST_PROBE: begin
        mid_nxt   = mid_sum[CNT_W:1];
        mem_raddr = mid_sum[IDX_W:1];
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (is_ins_r) begin
          // upper bound: first key above the new one
          if (key_gt) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + ONE_C;
          end
          if (lo_nxt < hi_nxt) begin
            state_nxt = ST_PROBE;
          end else begin
            slot_nxt  = lo_nxt;
            i_nxt     = count_r;
            pend_nxt  = 1'b0;
            state_nxt = ST_SHIFT;
          end
        end else begin
          // predecessor: last key not above the query
          if (key_gt) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r;
          end
          if (hi_nxt - lo_nxt > ONE_C) begin
            state_nxt = ST_PROBE;
          end else begin
            state_nxt = ST_VREAD;
          end
        end
      end
      ST_VREAD: begin
        mem_raddr = lo_r[IDX_W-1:0];
        state_nxt = ST_VWAIT;
      end
      ST_VWAIT: begin
        res_nxt.found_position = mem_rdata.value;
        state_nxt              = ST_RESP;
      end
      ST_SHIFT: begin
        // read entry i-1 and write it back one slot up on the next cycle
        if (pend_r) begin
          mem_we    = 1'b1;
          mem_waddr = wr_addr_r[IDX_W-1:0];
          mem_wdata = mem_rdata;
        end
        if (i_r > slot_r) begin
          mem_raddr   = IDX_W'(i_r - ONE_C);
          pend_nxt    = 1'b1;
          wr_addr_nxt = i_r;
          i_nxt       = i_r - ONE_C;
        end else if (pend_r) begin
          pend_nxt = 1'b0;
        end else begin
          mem_we          = 1'b1;
          mem_waddr       = slot_r[IDX_W-1:0];
          mem_wdata.key   = q_r;
          mem_wdata.value = src_r;
          count_nxt       = count_r + ONE_C;
          state_nxt       = ST_RESP;
        end
      end
      ST_RESP: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      pend_r  <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    slot_r    <= slot_nxt;
    i_r       <= i_nxt;
    wr_addr_r <= wr_addr_nxt;
    is_ins_r  <= is_ins_nxt;
    q_r       <= q_nxt;
    src_r     <= src_nxt;
    res_r     <= res_nxt;
  end

  assign req_ready = (state_r == ST_IDLE);
  assign res_valid = (state_r == ST_RESP);
  assign res       = res_r;

  a_we_only_shift: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> state_r == ST_SHIFT)
    else $error("table written outside an insert shift");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("entry count above table depth");

  a_search_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CMP |-> lo_r < hi_r)
    else $error("empty search window at compare");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SHIFT && state_nxt == ST_RESP |-> count_nxt == count_r + ONE_C)
    else $error("insert finished without count step");

endmodule

// ===== rtl/core/sorted_range_map_lookup_top.sv =====
`timescale 1ns / 1ps

// sorted range map lookup: table of (code position, source position) pairs kept
// in ascending key order, searched for the last key not above a query
// in_req (sink): req_type 0 clears, 1 inserts a pair after equal keys, 2 looks up;
//   one request at a time, ready is high only while the sequencer is idle
// out_rsp (source): one result per request, found_position and table_full,
//   held in an output register until taken
// clear, an unused code and an insert into a full table go straight to the result;
// a lookup runs a binary search over the entries held, then reads the value;
// an insert runs a binary search for its slot, then shifts the entries above
// it up one place and writes the new pair into the slot
// every step goes through the single shared compare unit and the one read,
// one write table memory; a shift moves one entry per cycle
// reset clears the sequencer, the entry count and the output valid;
// table contents are not cleared, unwritten entries never reach a result
// a stalled receiver holds the result; the next request is taken once the
// result has moved into the output register
module sorted_range_map_lookup_top #(
  parameter int TABLE_DEPTH = srml_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  srml_req_if.sink    in_req,
  srml_rsp_if.source  out_rsp
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // sequencer to table memory
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [IDX_W-1:0]   mem_raddr;
  srml_pkg::entry_t   mem_wdata;
  srml_pkg::entry_t   mem_rdata;

  // result handoff
  logic               res_valid;
  logic               res_take;
  srml_pkg::res_t     res;

  // output register
  logic               out_valid_r;
  srml_pkg::res_t     out_res_r;

  srml_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (in_req.valid),
    .req_ready       (in_req.ready),
    .req_type        (in_req.req_type),
    .code_position   (in_req.code_position),
    .source_position (in_req.source_position),
    .res_valid       (res_valid),
    .res_take        (res_take),
    .res             (res),
    .mem_we          (mem_we),
    .mem_waddr       (mem_waddr),
    .mem_wdata       (mem_wdata),
    .mem_raddr       (mem_raddr),
    .mem_rdata       (mem_rdata)
  );

  srml_store #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // result moves in when the output slot is empty or draining this cycle
  assign res_take = !out_valid_r || out_rsp.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && res_take) begin
      out_valid_r <= 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (res_valid && res_take) begin
      out_res_r <= res;
    end
  end

  assign out_rsp.valid          = out_valid_r;
  assign out_rsp.found_position = out_res_r.found_position;
  assign out_rsp.table_full     = out_res_r.table_full;

endmodule
